@@ rtl/md4_pkg.sv @@
package md4_pkg;

   localparam int WORD_W  = 32;
   localparam int ADDR_W  = 4;
   localparam int STEP_W  = 6;
   localparam int ROT_W   = 5;

   localparam logic [ADDR_W-1:0] LAST_ADDR = 4'hF;
   localparam logic [STEP_W-1:0] LAST_STEP = 6'd47;

   // round codes
   localparam logic [1:0] RND_F = 2'd0;
   localparam logic [1:0] RND_G = 2'd1;
   localparam logic [1:0] RND_H = 2'd2;

   localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
   localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
   localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
   localparam logic [WORD_W-1:0] IV_D = 32'h10325476;
   localparam logic [3:0][WORD_W-1:0] IV_WORDS = {IV_D, IV_C, IV_B, IV_A};

   localparam logic [WORD_W-1:0] K_G = 32'h5a827999;
   localparam logic [WORD_W-1:0] K_H = 32'h6ed9eba1;

   // one queued beat, already classified by the front end
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [ADDR_W-1:0] addr;
      logic              load_iv;
      logic              compress;
      logic              emit;
   } cmd_type;

   function automatic logic [WORD_W-1:0] mix_fn(input logic [1:0] rnd,
                                               input logic [WORD_W-1:0] x,
                                               input logic [WORD_W-1:0] y,
                                               input logic [WORD_W-1:0] z);
      logic [WORD_W-1:0] r;
      case (rnd)
         RND_F: r = (x & y) | (~x & z);
         RND_G: r = (x & y) | (x & z) | (y & z);
         default: r = x ^ y ^ z;
      endcase
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] round_k(input logic [1:0] rnd);
      logic [WORD_W-1:0] k;
      case (rnd)
         RND_F: k = '0;
         RND_G: k = K_G;
         default: k = K_H;
      endcase
      return k;
   endfunction

   function automatic logic [ROT_W-1:0] rot_amt(input logic [1:0] rnd,
                                               input logic [1:0] pos);
      logic [ROT_W-1:0] s;
      case ({rnd, pos})
         {RND_F, 2'd0}: s = 5'd3;
         {RND_F, 2'd1}: s = 5'd7;
         {RND_F, 2'd2}: s = 5'd11;
         {RND_F, 2'd3}: s = 5'd19;
         {RND_G, 2'd0}: s = 5'd3;
         {RND_G, 2'd1}: s = 5'd5;
         {RND_G, 2'd2}: s = 5'd9;
         {RND_G, 2'd3}: s = 5'd13;
         {RND_H, 2'd0}: s = 5'd3;
         {RND_H, 2'd1}: s = 5'd9;
         {RND_H, 2'd2}: s = 5'd11;
         default: s = 5'd15;
      endcase
      return s;
   endfunction

   // message word order of each round
   function automatic logic [ADDR_W-1:0] word_sel(input logic [1:0] rnd,
                                                 input logic [ADDR_W-1:0] pos);
      logic [ADDR_W-1:0] w;
      case (rnd)
         RND_F: w = pos;
         RND_G: w = {pos[1:0], pos[3:2]};
         default: w = {pos[0], pos[1], pos[2], pos[3]};
      endcase
      return w;
   endfunction

   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                               input logic [ROT_W-1:0] n);
      logic [2*WORD_W-1:0] t;
      t = {v, v} << n;
      return t[2*WORD_W-1:WORD_W];
   endfunction

endpackage

@@ rtl/md4_front.sv @@
module md4_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [md4_pkg::WORD_W-1:0]     req_message_word,
   input  logic                           req_first_word,
   input  logic                           req_final_word,
   output logic                           cmd_valid,
   output md4_pkg::cmd_type               cmd,
   input  logic                           cmd_stall
);

   logic [md4_pkg::ADDR_W-1:0] count_ff, count_in;
   logic [md4_pkg::ADDR_W-1:0] base;
   md4_pkg::cmd_type           cmd_new;
   md4_pkg::cmd_type           q_ff [2];
   logic                       wr_ptr_ff, wr_ptr_in;
   logic                       rd_ptr_ff, rd_ptr_in;
   logic [1:0]                 fill_ff, fill_in;
   logic                       push, pop;

   assign req_stall = (fill_ff == 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid & ~req_stall;
   assign pop       = cmd_valid & ~cmd_stall;

   // classify the beat: buffer slot, chain restart, block end, digest request
   always_comb begin
      base             = req_first_word ? '0 : count_ff;
      cmd_new.word     = req_message_word;
      cmd_new.addr     = base;
      cmd_new.load_iv  = req_first_word;
      cmd_new.compress = (base == md4_pkg::LAST_ADDR);
      cmd_new.emit     = req_final_word;
   end

   always_comb begin
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         count_in  = req_final_word ? '0 : base + 4'd1;
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push, pop})
         2'b10: fill_in = fill_ff + 2'd1;
         2'b01: fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

@@ rtl/md4_back.sv @@
module md4_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   input  md4_pkg::cmd_type               cmd,
   output logic                           cmd_stall,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [md4_pkg::WORD_W-1:0]     rsp_digest_word,
   output logic [1:0]                     rsp_digest_index,
   output logic                           rsp_digest_last
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PRIME = 3'd1;
   localparam logic [2:0] ST_RUN   = 3'd2;
   localparam logic [2:0] ST_ADD   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]                        state_ff, state_in;
   logic [md4_pkg::STEP_W-1:0]        step_ff, step_in;
   logic                              load_bank_ff, load_bank_in;
   logic                              cmp_bank_ff, cmp_bank_in;
   logic                              emit_pend_ff, emit_pend_in;
   logic [1:0]                        emit_idx_ff, emit_idx_in;
   logic [3:0][md4_pkg::WORD_W-1:0]   chain_ff, chain_in;
   logic [3:0][md4_pkg::WORD_W-1:0]   v_ff, v_in;
   logic [md4_pkg::WORD_W-1:0]        x_ff;
   logic [md4_pkg::WORD_W-1:0]        mem_ff [2*16];
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [md4_pkg::WORD_W-1:0]        rsp_word_ff, rsp_word_in;
   logic [1:0]                        rsp_index_ff, rsp_index_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              take, can, plain, rsp_free;
   logic [md4_pkg::STEP_W-1:0]        step_nx;
   logic [4:0]                        rd_addr;
   logic [1:0]                        rnd;
   logic [md4_pkg::WORD_W-1:0]        f_val, sum, rot;

   // a plain store only touches the loading bank, so it may overlap a compression
   assign plain     = ~(cmd.load_iv | cmd.compress | cmd.emit);
   assign can       = (state_ff == ST_IDLE) ||
                      ((state_ff inside {ST_PRIME, ST_RUN, ST_ADD}) && plain);
   assign cmd_stall = ~can;
   assign take      = cmd_valid & can;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digest_word  = rsp_word_ff;
   assign rsp_digest_index = rsp_index_ff;
   assign rsp_digest_last  = rsp_last_ff;

   // prefetch the message word of the next step
   assign step_nx = (state_ff == ST_PRIME) ? '0 : step_ff + 6'd1;
   assign rd_addr = {cmp_bank_ff, md4_pkg::word_sel(step_nx[5:4], step_nx[3:0])};

   assign rnd   = step_ff[5:4];
   assign f_val = md4_pkg::mix_fn(rnd, v_ff[1], v_ff[2], v_ff[3]);
   assign sum   = v_ff[0] + f_val + x_ff + md4_pkg::round_k(rnd);
   assign rot   = md4_pkg::rotl32(sum, md4_pkg::rot_amt(rnd, step_ff[1:0]));

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      load_bank_in = load_bank_ff;
      cmp_bank_in  = cmp_bank_ff;
      emit_pend_in = emit_pend_ff;
      emit_idx_in  = emit_idx_ff;
      chain_in     = chain_ff;
      v_in         = v_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_word_in  = rsp_word_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (cmd.load_iv) begin
                  chain_in = md4_pkg::IV_WORDS;
               end
               if (cmd.compress) begin
                  cmp_bank_in  = load_bank_ff;
                  load_bank_in = ~load_bank_ff;
                  v_in         = chain_ff;
                  emit_pend_in = cmd.emit;
                  state_in     = ST_PRIME;
               end else if (cmd.emit) begin
                  emit_idx_in = '0;
                  state_in    = ST_EMIT;
               end
            end
         end
         ST_PRIME: begin
            step_in  = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            // rotate roles: next target is the old D
            v_in[0] = v_ff[3];
            v_in[1] = rot;
            v_in[2] = v_ff[1];
            v_in[3] = v_ff[2];
            step_in = step_nx;
            if (step_ff == md4_pkg::LAST_STEP) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 4; i++) begin
               chain_in[i] = chain_ff[i] + v_ff[i];
            end
            if (emit_pend_ff) begin
               emit_idx_in = '0;
               state_in    = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = chain_ff[emit_idx_ff];
               rsp_index_in = emit_idx_ff;
               rsp_last_in  = (emit_idx_ff == 2'd3);
               emit_idx_in  = emit_idx_ff + 2'd1;
               if (emit_idx_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         load_bank_ff <= 1'b0;
         cmp_bank_ff  <= 1'b0;
         emit_pend_ff <= 1'b0;
         emit_idx_ff  <= '0;
         chain_ff     <= md4_pkg::IV_WORDS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         load_bank_ff <= load_bank_in;
         cmp_bank_ff  <= cmp_bank_in;
         emit_pend_ff <= emit_pend_in;
         emit_idx_ff  <= emit_idx_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff         <= v_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // two-bank block buffer: one write, one registered read
   always_ff @(posedge clock) begin
      if (take) begin
         mem_ff[{load_bank_ff, cmd.addr}] <= cmd.word;
      end
      x_ff <= mem_ff[rd_addr];
   end

endmodule

@@ rtl/md4_block_hash.sv @@
// channel  direction  handshake              fields
// req      in         req_valid, req_stall   message_word, first_word, final_word
// rsp      out        rsp_valid, rsp_stall   digest_word, digest_index, digest_last
//
// Words enter a two-entry queue at one per cycle while not stalled. The 16th word of a
// block starts the round-step unit: a read-prime state, 48 steps at one per cycle, a
// chaining add, then the idle state that takes the next block end; the next block fills
// the other buffer bank meanwhile.
// A final word yields 4 result beats, one per cycle when not stalled.
// Reset loads the chaining words with the initial values; the block buffer is not cleared.
// A stalled result holds in the output register while the next words are taken.
module md4_block_hash (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [md4_pkg::WORD_W-1:0]     req_message_word,
   input  logic                           req_first_word,
   input  logic                           req_final_word,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [md4_pkg::WORD_W-1:0]     rsp_digest_word,
   output logic [1:0]                     rsp_digest_index,
   output logic                           rsp_digest_last
);

   logic             cmd_valid;
   logic             cmd_stall;
   md4_pkg::cmd_type cmd;

   md4_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_message_word (req_message_word),
      .req_first_word   (req_first_word),
      .req_final_word   (req_final_word),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_stall        (cmd_stall)
   );

   md4_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_stall        (cmd_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_digest_index (rsp_digest_index),
      .rsp_digest_last  (rsp_digest_last)
   );

`ifndef SYNTH
   a_queue_holds: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> cmd_valid)
      else $error("accepted beat missing from queue");

   a_compress_at_end: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd.compress |-> cmd.addr == md4_pkg::LAST_ADDR && !cmd.load_iv)
      else $error("compression requested off block end");

   a_last_is_d: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_digest_last |-> rsp_digest_index == 2'd3)
      else $error("last flag on wrong digest word");
`endif

endmodule

@@ sim/tb_md4_block_hash.sv @@
`timescale 1ns / 1ps

module tb_md4_block_hash;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 120;

   typedef struct {
      logic [md4_pkg::WORD_W-1:0] word;
      logic                       first;
      logic                       fin;
   } msg_beat_type;

   typedef struct {
      logic [md4_pkg::WORD_W-1:0] word;
      logic [1:0]                 index;
      logic                       last;
   } digest_beat_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [md4_pkg::WORD_W-1:0] req_message_word = '0;
   logic                       req_first_word = 1'b0;
   logic                       req_final_word = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [md4_pkg::WORD_W-1:0] rsp_digest_word;
   logic [1:0]                 rsp_digest_index;
   logic                       rsp_digest_last;

   md4_block_hash u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_message_word (req_message_word),
      .req_first_word   (req_first_word),
      .req_final_word   (req_final_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_digest_index (rsp_digest_index),
      .rsp_digest_last  (rsp_digest_last)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   msg_beat_type    pending_words[$];
   digest_beat_type digest_due[$];
   msg_beat_type    next_word;

   // predictor state
   logic [md4_pkg::WORD_W-1:0] chain_val[4];
   logic [md4_pkg::WORD_W-1:0] msg_block[16];
   logic [3:0]                 fill_count;

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_asked = 0;
   int  hold_served = 0;
   int  hold_left = 0;
   logic req_taken = 1'b0;
   int  cycle_count = 0;
   int  fail_count = 0;
   int  words_taken = 0;
   int  messages_queued = 0;
   int  blocks_done = 0;
   int  digest_beats = 0;

   function automatic logic [md4_pkg::WORD_W-1:0] md4_rotl(input logic [31:0] v,
                                                          input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic void load_iv();
      chain_val[0] = md4_pkg::IV_A;
      chain_val[1] = md4_pkg::IV_B;
      chain_val[2] = md4_pkg::IV_C;
      chain_val[3] = md4_pkg::IV_D;
   endfunction

   function automatic void md4_compress();
      int          shift_tab[3][4];
      logic [31:0] v[4];
      logic [31:0] b, c, d, mix, k, sum;
      logic [1:0]  rnd;
      logic [3:0]  pos, sel;
      int          t;
      shift_tab = '{'{3, 7, 11, 19}, '{3, 5, 9, 13}, '{3, 9, 11, 15}};
      for (int i = 0; i < 4; i++) v[i] = chain_val[i];
      for (int step = 0; step < 48; step++) begin
         rnd = 2'(step / 16);
         pos = 4'(step % 16);
         // target register walks A, D, C, B
         t = (4 - pos[1:0]) & 3;
         b = v[(t + 1) & 3];
         c = v[(t + 2) & 3];
         d = v[(t + 3) & 3];
         case (rnd)
            md4_pkg::RND_F: begin
               mix = (b & c) | (~b & d);
               k = '0;
               sel = pos;
            end
            md4_pkg::RND_G: begin
               mix = (b & c) | (b & d) | (c & d);
               k = md4_pkg::K_G;
               sel = 4'((pos % 4) * 4 + pos / 4);
            end
            default: begin
               mix = b ^ c ^ d;
               k = md4_pkg::K_H;
               for (int j = 0; j < 4; j++) sel[j] = pos[3 - j];
            end
         endcase
         sum = v[t] + mix + msg_block[sel] + k;
         v[t] = md4_rotl(sum, shift_tab[rnd][pos[1:0]]);
      end
      for (int i = 0; i < 4; i++) chain_val[i] = chain_val[i] + v[i];
      blocks_done++;
   endfunction

   function automatic void absorb_word(input logic [31:0] w, input logic first,
                                       input logic fin);
      digest_beat_type e;
      if (first) begin
         load_iv();
         fill_count = '0;
      end
      msg_block[fill_count] = w;
      fill_count = fill_count + 4'd1;
      if (fill_count == 4'd0) md4_compress();
      if (fin) begin
         fill_count = '0;
         for (int i = 0; i < 4; i++) begin
            e.word = chain_val[i];
            e.index = 2'(i);
            e.last = (i == 3);
            digest_due.push_back(e);
         end
      end
   endfunction

   function automatic void check_digest_beat();
      digest_beat_type e;
      digest_beats++;
      if (digest_due.size() == 0) begin
         $error("unexpected digest beat: word %h index %0d last %0b",
                rsp_digest_word, rsp_digest_index, rsp_digest_last);
         fail_count++;
      end else begin
         e = digest_due.pop_front();
         if (rsp_digest_word !== e.word) begin
            $error("digest_word: expected %h, got %h", e.word, rsp_digest_word);
            fail_count++;
         end
         if (rsp_digest_index !== e.index) begin
            $error("digest_index: expected %0d, got %0d", e.index, rsp_digest_index);
            fail_count++;
         end
         if (rsp_digest_last !== e.last) begin
            $error("digest_last: expected %0b, got %0b", e.last, rsp_digest_last);
            fail_count++;
         end
      end
   endfunction

   // driver: pick a new beat only once the current one is gone
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_word = pending_words.pop_front();
            req_valid <= 1'b1;
            req_message_word <= next_word.word;
            req_first_word <= next_word.first;
            req_final_word <= next_word.fin;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stall, or a long hold-off when asked
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_served) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            words_taken++;
            absorb_word(req_message_word, req_first_word, req_final_word);
         end
         if (rsp_valid && !rsp_stall) check_digest_beat();
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d digest beats outstanding",
                  cycle_count, digest_due.size());
         $display("md4_block_hash regression: fail");
         $finish;
      end
   end

   task automatic push_word(input logic [31:0] w, input logic first, input logic fin);
      msg_beat_type m;
      m.word = w;
      m.first = first;
      m.fin = fin;
      pending_words.push_back(m);
   endtask

   function automatic logic [31:0] rand_word();
      int pick;
      pick = $urandom_range(15);
      if (pick == 0) return 32'h0;
      if (pick == 1) return 32'hffffffff;
      return $urandom();
   endfunction

   // mostly whole messages, some partial blocks, abandoned runs and noise
   task automatic queue_messages(input int n_items);
      int made, kind, len;
      logic with_first, with_final;
      made = 0;
      while (made < n_items) begin
         kind = $urandom_range(99);
         if (kind < 8) begin
            push_word(rand_word(), 1'($urandom_range(1)), 1'($urandom_range(1)));
            made++;
         end else begin
            if (kind < 45) len = 16;
            else if (kind < 60) len = 32;
            else len = $urandom_range(1, 15);
            with_first = ($urandom_range(9) != 0);
            with_final = ($urandom_range(11) != 0);
            for (int i = 0; i < len; i++)
               push_word(rand_word(), with_first && i == 0, with_final && i == len - 1);
            made += len;
            messages_queued++;
         end
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_valid || digest_due.size() != 0);
   endtask

   initial begin
      load_iv();
      fill_count = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // digest right after reset without a first flag: initial values
      push_word(32'h12345678, 1'b0, 1'b1);
      // first and final together
      push_word(32'hffffffff, 1'b1, 1'b1);
      // "abc", padded to one block, with first and final
      push_word(32'h80636261, 1'b1, 1'b0);
      for (int i = 1; i < 14; i++) push_word(32'h0, 1'b0, 1'b0);
      push_word(32'h00000018, 1'b0, 1'b0);
      push_word(32'h0, 1'b0, 1'b1);
      // continue from the chaining words, final inside a partial block
      push_word(32'h0, 1'b0, 1'b1);
      push_word(32'hffffffff, 1'b0, 1'b0);
      push_word(32'h00000000, 1'b0, 1'b0);
      push_word(32'hffffffff, 1'b0, 1'b1);
      messages_queued += 5;
      wait_idle();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
         endcase
         queue_messages(105);
         wait_idle();
      end

      // long output hold-off with the sender at full rate: short messages back up
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_asked = hold_asked + 1;
      @(negedge clock);
      for (int m = 0; m < 8; m++) begin
         for (int i = 0; i < 3; i++) push_word(rand_word(), i == 0, i == 2);
         messages_queued++;
      end
      wait_idle();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (digest_due.size() != 0) begin
         $error("%0d digest beats never arrived", digest_due.size());
         fail_count++;
      end
      $display("%0d message words in %0d messages, %0d blocks compressed",
               words_taken, messages_queued, blocks_done);
      $display("%0d digest beats checked across idle, stall and hold-off phases",
               digest_beats);
      if (fail_count == 0) begin
         $display("md4_block_hash regression: pass");
      end else begin
         $display("md4_block_hash regression: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/md4_pkg.sv
rtl/md4_front.sv
rtl/md4_back.sv
rtl/md4_block_hash.sv
sim/tb_md4_block_hash.sv
